[src/kwm_pkg.sv]
package kwm_pkg;

  localparam int LISTS = 8;
  localparam int DEPTH = 16;

  localparam int IDW   = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WORDS = LISTS * DEPTH;
  localparam int AW    = $clog2(WORDS);
  localparam int VW    = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } state_e;

  typedef struct packed {
    logic          op;
    logic [2:0]    list_id;
    logic [VW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic          has_value;
    logic [VW-1:0] out_value;
    logic [2:0]    source_list;
    logic          is_last;
    logic          error_flag;
  } out_item_t;

  typedef struct packed {
    logic           ok;
    logic [IDW-1:0] idx;
    logic [VW-1:0]  val;
  } pick_t;

endpackage

[src/kwm_ram.sv]
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/kwm_tree.sv]
module kwm_tree (
  input  logic [kwm_pkg::LISTS-1:0][kwm_pkg::VW-1:0] head_i,
  input  logic [kwm_pkg::LISTS-1:0]                  ok_i,
  output kwm_pkg::pick_t                             pick_o
);

  localparam int P = 1 << kwm_pkg::IDW;

  kwm_pkg::pick_t node [2*P-1];

  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < kwm_pkg::LISTS) begin
        node[P-1+i].ok  = ok_i[i];
        node[P-1+i].val = head_i[i];
      end else begin
        node[P-1+i].ok  = 1'b0;
        node[P-1+i].val = '0;
      end
      node[P-1+i].idx = kwm_pkg::IDW'(i);
    end
    // left child always holds the lower list numbers, so ties keep it
    for (int n = P - 2; n >= 0; n--) begin
      if (node[2*n+2].ok && (!node[2*n+1].ok ||
          ($signed(node[2*n+2].val) < $signed(node[2*n+1].val)))) begin
        node[n] = node[2*n+2];
      end else begin
        node[n] = node[2*n+1];
      end
    end
  end

  assign pick_o = node[0];

endmodule

[src/k_way_sorted_merge_core.sv]
// K-way sorted merge core.
// Input channel (in_valid_i/in_ready_o, in_data_i): a push appends value to
// the FIFO of list_id; a pop takes the smallest head over all lists, ties to
// the lower list number. Every input transfer produces one output transfer
// (out_valid_o/out_ready_o side, out_data_o) carrying value, source list,
// last-element and error flags.
// The result of each transfer is registered into the output queue. A pop that
// leaves its list non-empty moves the FSM to a refill state, where input is
// held off: the next head of that list is read from the element RAM (one
// registered read port) and written into the head cache; the comparator tree
// works on the cached heads only. Pushes and other pops do not hold off input.
// Output has a two-entry queue, so a new item is taken while one result waits;
// with both entries full, in_ready_o drops until the receiver takes one.
// Reset clears fill counts, read pointers, FSM and output queue; the element
// RAM is not cleared and needs no init pass.
module k_way_sorted_merge_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kwm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kwm_pkg::out_item_t out_data_o
);

  localparam int IDW = kwm_pkg::IDW;
  localparam int PW  = kwm_pkg::PW;
  localparam int CW  = kwm_pkg::CW;
  localparam int AW  = kwm_pkg::AW;
  localparam int SW  = CW + 1;

  kwm_pkg::state_e state_q, state_d;

  logic [kwm_pkg::LISTS-1:0][kwm_pkg::VW-1:0] hd_q, hd_d;
  logic [kwm_pkg::LISTS-1:0][PW-1:0]          rp_q, rp_d;
  logic [kwm_pkg::LISTS-1:0][CW-1:0]          fc_q, fc_d;
  logic [kwm_pkg::LISTS-1:0]                  hd_ok;
  logic [IDW-1:0]                             rf_idx_q, rf_idx_d;

  kwm_pkg::out_item_t out_q, out_d, skid_q, skid_d, res;
  logic               out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  kwm_pkg::pick_t pick;

  logic                 accept, is_pop, id_ok, push_ok, take, refill;
  logic [IDW-1:0]       sel;
  logic [SW-1:0]        wsum;
  logic [PW-1:0]        wpos, rp_next;
  logic [CW-1:0]        nfill;
  logic                 all_empty;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [kwm_pkg::VW-1:0] ram_rdata;

  always_comb begin
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      hd_ok[i] = (fc_q[i] != '0);
    end
  end

  kwm_tree u_tree (
    .head_i (hd_q),
    .ok_i   (hd_ok),
    .pick_o (pick)
  );

  kwm_ram #(
    .WIDTH (kwm_pkg::VW),
    .WORDS (kwm_pkg::WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.value),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (refill) begin
          state_d = kwm_pkg::ST_REFILL;
        end
      end
      kwm_pkg::ST_REFILL: begin
        state_d = kwm_pkg::ST_IDLE;
      end
      default: state_d = kwm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      kwm_pkg::ST_IDLE:   in_ready_o = !skid_vld_q;
      kwm_pkg::ST_REFILL: in_ready_o = 1'b0;
      default:            in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign is_pop = (in_data_i.op == kwm_pkg::OP_POP);
  assign id_ok  = (32'(in_data_i.list_id) < kwm_pkg::LISTS);
  assign sel    = IDW'(in_data_i.list_id);

  always_comb begin
    push_ok = id_ok && (fc_q[sel] < CW'(kwm_pkg::DEPTH));
    wsum    = SW'(rp_q[sel]) + SW'(fc_q[sel]);
    if (wsum >= SW'(kwm_pkg::DEPTH)) begin
      wsum = wsum - SW'(kwm_pkg::DEPTH);
    end
    wpos  = PW'(wsum);
    nfill = fc_q[pick.idx] - CW'(1);
    if (rp_q[pick.idx] == PW'(kwm_pkg::DEPTH - 1)) begin
      rp_next = '0;
    end else begin
      rp_next = rp_q[pick.idx] + PW'(1);
    end
    all_empty = 1'b1;
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      if (IDW'(i) == pick.idx) begin
        if (fc_q[i] != CW'(1)) all_empty = 1'b0;
      end else begin
        if (fc_q[i] != '0) all_empty = 1'b0;
      end
    end
  end

  assign refill = accept && is_pop && pick.ok && (nfill != '0);
  assign ram_we = accept && !is_pop && push_ok;

  always_comb begin
    if (ram_we) begin
      ram_addr = AW'(AW'(sel) * AW'(kwm_pkg::DEPTH) + AW'(wpos));
    end else begin
      ram_addr = AW'(AW'(pick.idx) * AW'(kwm_pkg::DEPTH) + AW'(rp_next));
    end
  end

  always_comb begin
    hd_d     = hd_q;
    rp_d     = rp_q;
    fc_d     = fc_q;
    rf_idx_d = rf_idx_q;
    res      = '0;
    if (state_q == kwm_pkg::ST_REFILL) begin
      hd_d[rf_idx_q] = ram_rdata;
    end
    if (accept) begin
      if (!is_pop) begin
        res.error_flag = !push_ok;
        if (push_ok) begin
          fc_d[sel] = fc_q[sel] + CW'(1);
          if (fc_q[sel] == '0) begin
            hd_d[sel] = in_data_i.value;
          end
        end
      end else if (!pick.ok) begin
        res.error_flag = 1'b1;
      end else begin
        res.has_value   = 1'b1;
        res.out_value   = pick.val;
        res.source_list = 3'(pick.idx);
        res.is_last     = all_empty;
        fc_d[pick.idx]  = nfill;
        rp_d[pick.idx]  = rp_next;
        rf_idx_d        = pick.idx;
      end
    end
  end

  // two-entry output queue
  assign take = out_vld_q && out_ready_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_q || take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kwm_pkg::ST_IDLE;
      rp_q       <= '0;
      fc_q       <= '0;
      rf_idx_q   <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rp_q       <= rp_d;
      fc_q       <= fc_d;
      rf_idx_q   <= rf_idx_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q   <= hd_d;
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[src/kwm_checker.sv]
module kwm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kwm_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_err_no_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.has_value && out_data_o.error_flag))
    else $error("error flag together with a value");

  a_last_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_last |-> out_data_o.has_value)
    else $error("last flag without a value");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_value |->
      out_data_o.out_value == '0 && out_data_o.source_list == '0)
    else $error("no-value result carries data");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (.*);

[bench/k_way_sorted_merge_core_tb.sv]
`timescale 1ns / 1ps

module k_way_sorted_merge_core_tb;
  import kwm_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  k_way_sorted_merge_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  class merge_scoreboard;
    logic [VW-1:0] store [LISTS][DEPTH];
    int unsigned   head [LISTS];
    int unsigned   fill [LISTS];
    out_item_t     pending_q[$];
    int unsigned   errors;
    int unsigned   n_push, n_pop, n_drop, n_empty_pop, n_last, n_results;

    function new();
      foreach (head[i]) begin
        head[i] = 0;
        fill[i] = 0;
      end
      errors = 0;
      n_push = 0;
      n_pop = 0;
      n_drop = 0;
      n_empty_pop = 0;
      n_last = 0;
      n_results = 0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int        best;
      bool_dummy();
      r = '0;
      best = -1;
      if (it.op == OP_PUSH) begin
        n_push++;
        if (int'(it.list_id) >= LISTS || fill[it.list_id] == DEPTH) begin
          r.error_flag = 1'b1;
          n_drop++;
        end else begin
          store[it.list_id][(head[it.list_id] + fill[it.list_id]) % DEPTH] = it.value;
          fill[it.list_id]++;
        end
      end else begin
        n_pop++;
        for (int l = 0; l < LISTS; l++) begin
          if (fill[l] != 0) begin
            if (best < 0 || $signed(store[l][head[l]]) < $signed(store[best][head[best]]))
              best = l;
          end
        end
        if (best < 0) begin
          r.error_flag = 1'b1;
          n_empty_pop++;
        end else begin
          r.has_value   = 1'b1;
          r.out_value   = store[best][head[best]];
          r.source_list = 3'(best);
          head[best]    = (head[best] + 1) % DEPTH;
          fill[best]--;
          r.is_last = 1'b1;
          foreach (fill[l]) if (fill[l] != 0) r.is_last = 1'b0;
          if (r.is_last) n_last++;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void bool_dummy();
    endfunction

    function void field_ok(string name, logic [VW-1:0] exp_v, logic [VW-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending_q.size() == 0) begin
        $error("result transfer with no pending expectation: 0x%0h", got);
        errors++;
        return;
      end
      exp_item = pending_q.pop_front();
      n_results++;
      field_ok("has_value", VW'(exp_item.has_value), VW'(got.has_value));
      field_ok("out_value", exp_item.out_value, got.out_value);
      field_ok("source_list", VW'(exp_item.source_list), VW'(got.source_list));
      field_ok("is_last", VW'(exp_item.is_last), VW'(got.is_last));
      field_ok("error_flag", VW'(exp_item.error_flag), VW'(got.error_flag));
    endfunction
  endclass

  merge_scoreboard   sb;
  int                idle_pct;
  int                stall_pct;
  int                hold_cycles;
  logic signed [31:0] tail [LISTS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls plus long hold-off, checks every transfer
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  function automatic in_item_t mk(logic op, int l, logic [VW-1:0] v);
    in_item_t it;
    it.op      = op;
    it.list_id = 3'(l);
    it.value   = v;
    return it;
  endfunction

  // ascending values per list, with some noise and restarts
  function automatic in_item_t rand_item(int pop_pct, int hot);
    int     l;
    longint nv;
    l = (hot >= 0 && $urandom_range(99) < 70) ? hot : $urandom_range(7);
    if ($urandom_range(99) < pop_pct) return mk(OP_POP, l, $urandom);
    if (l >= LISTS || $urandom_range(99) < 10) return mk(OP_PUSH, l, $urandom);
    if (sb.fill[l] == 0 || $urandom_range(99) < 3) begin
      case ($urandom_range(3))
        0:       tail[l] = 32'sh8000_0000;
        1:       tail[l] = 32'sh7fff_fff0;
        default: tail[l] = $urandom;
      endcase
    end else begin
      nv = longint'(tail[l]) + (($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 20));
      tail[l] = (nv > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(nv);
    end
    return mk(OP_PUSH, l, tail[l]);
  endfunction

  task automatic run_phase(int idle, int stall, int pop_pct, int hot, int count, int hold);
    idle_pct    = idle;
    stall_pct   = stall;
    hold_cycles = hold;
    repeat (count) send(rand_item(pop_pct, hot));
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    foreach (tail[l]) tail[l] = '0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pop, extremes, tie on equal heads, last element, full list
    send(mk(OP_POP, 0, '0));
    send(mk(OP_PUSH, 7, 32'h7fff_ffff));
    send(mk(OP_PUSH, 0, 32'h8000_0000));
    send(mk(OP_PUSH, 4, 32'h8000_0000));
    send(mk(OP_PUSH, 1, 32'hffff_ffff));
    send(mk(OP_POP, 5, 32'hdead_beef));
    send(mk(OP_POP, 0, '0));
    send(mk(OP_POP, 7, 32'hffff_ffff));
    send(mk(OP_POP, 0, '0));
    send(mk(OP_POP, 3, '0));
    for (int i = 0; i <= DEPTH; i++) send(mk(OP_PUSH, 2, VW'(i)));
    drain();

    run_phase(0, 0, 35, -1, 110, 0);
    run_phase(57, 0, 60, -1, 110, 0);
    run_phase(0, 57, 25, 3, 110, 0);
    run_phase(14, 14, 70, -1, 110, 0);
    run_phase(0, 0, 40, -1, 80, 150);
    run_phase(0, 0, 50, 6, 100, 0);
    run_phase(14, 14, 75, -1, 80, 0);

    repeat (20) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Covered %0d pushes (%0d dropped on full list) and %0d pops (%0d on empty).",
             sb.n_push, sb.n_drop, sb.n_pop, sb.n_empty_pop);
    $display("Checked %0d results, %0d emptied every list; %0d mismatches.",
             sb.n_results, sb.n_last, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
